@@ hw/rtl/short_descriptor_table_walk_unit_defines.svh @@
// assertion macros used by the table walk sequencer rtl
`ifndef SHORT_DESCRIPTOR_TABLE_WALK_UNIT_DEFINES_SVH
`define SHORT_DESCRIPTOR_TABLE_WALK_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SDTW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sdtw assertion failed");
`define SDTW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sdtw assertion failed");
`else
`define SDTW_ASSERT(lbl, prop)
`define SDTW_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ hw/rtl/sdtw_pkg.sv @@
// types, codes and descriptor merge for the short-descriptor table walker
`timescale 1ns / 1ps

package sdtw_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  localparam logic [31:0] SECTION_MASK    = 32'hFFF0_0000;
  localparam logic [31:0] SUPER_MASK      = 32'hFF00_0000;
  localparam logic [31:0] SMALL_PAGE_MASK = 32'hFFFF_F000;
  localparam logic [31:0] LARGE_PAGE_MASK = 32'hFFFF_0000;
  localparam int          SUPER_BIT       = 18;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_L1,
    ST_L2,
    ST_PUSH
  } walk_state_t;

  typedef struct packed {
    logic [31:0] phys_addr;
    logic        fault;
  } walk_res_t;

  // final descriptor merged with the virtual address under its level mask; bits [1:0] zero fault
  function automatic walk_res_t merge_desc(input logic [31:0] entry, input logic [31:0] va,
                                           input logic is_l2);
    walk_res_t   res;
    logic [31:0] mask;
    if (is_l2) begin
      mask = entry[1] ? SMALL_PAGE_MASK : LARGE_PAGE_MASK;
    end else begin
      mask = entry[SUPER_BIT] ? SUPER_MASK : SECTION_MASK;
    end
    if (entry[1:0] == 2'b00) begin
      res.phys_addr = 32'h0;
      res.fault     = 1'b1;
    end else begin
      res.phys_addr = (entry & mask) | (va & ~mask);
      res.fault     = 1'b0;
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/sdtw_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps

module sdtw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/sdtw_walk.sv @@
// walk sequencer: clear pass, table writes, two-level lookup and result register
`timescale 1ns / 1ps
`include "short_descriptor_table_walk_unit_defines.svh"

module sdtw_walk #(
  parameter int WALK_ADDR_BITS = 18
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [31:0]               table_base,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic [31:0]               in_addr,
  input  logic [31:0]               in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sdtw_pkg::walk_res_t       out_res,
  output logic                      ram_we,
  output logic [WALK_ADDR_BITS-3:0] ram_addr,
  output logic [31:0]               ram_wdata,
  input  logic [31:0]               ram_rdata
);

  localparam int AW = WALK_ADDR_BITS - 2;

  sdtw_pkg::walk_state_t state_r, state_nxt;
  logic [AW-1:0]         clr_cnt_r;
  logic [31:0]           va_r;
  sdtw_pkg::walk_res_t   pend_r;
  sdtw_pkg::walk_res_t   out_r;
  logic                  out_valid_r;
  logic [31:0]           l1_byte;
  logic [31:0]           l2_byte;
  logic                  out_free;
  logic                  in_fire;

  assign l1_byte  = {table_base[31:14], in_addr[31:20], 2'b00};
  assign l2_byte  = {ram_rdata[31:10], 10'b0} + {22'b0, va_r[19:12], 2'b00};
  assign out_free = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sdtw_pkg::ST_CLEAR: if (clr_cnt_r == '1) state_nxt = sdtw_pkg::ST_IDLE;
      sdtw_pkg::ST_IDLE: begin
        if (in_valid && in_op == sdtw_pkg::OP_XLATE) state_nxt = sdtw_pkg::ST_L1;
      end
      sdtw_pkg::ST_L1: state_nxt = ram_rdata[0] ? sdtw_pkg::ST_L2 : sdtw_pkg::ST_PUSH;
      sdtw_pkg::ST_L2: state_nxt = sdtw_pkg::ST_PUSH;
      sdtw_pkg::ST_PUSH: if (out_free) state_nxt = sdtw_pkg::ST_IDLE;
      default: state_nxt = sdtw_pkg::ST_IDLE;
    endcase
  end

  // memory port and handshake
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      sdtw_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt_r;
      end
      sdtw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_op == sdtw_pkg::OP_WRITE) begin
          ram_we    = in_valid;
          ram_addr  = in_addr[WALK_ADDR_BITS-1:2];
          ram_wdata = in_data;
        end else begin
          ram_addr = l1_byte[WALK_ADDR_BITS-1:2];
        end
      end
      sdtw_pkg::ST_L1: ram_addr = l2_byte[WALK_ADDR_BITS-1:2];
      sdtw_pkg::ST_L2, sdtw_pkg::ST_PUSH: ram_addr = '0;
      default: ram_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdtw_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == sdtw_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == sdtw_pkg::ST_PUSH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      va_r <= in_addr;
    end
    if (state_r == sdtw_pkg::ST_L1) begin
      pend_r <= sdtw_pkg::merge_desc(ram_rdata, va_r, 1'b0);
    end else if (state_r == sdtw_pkg::ST_L2) begin
      pend_r <= sdtw_pkg::merge_desc(ram_rdata, va_r, 1'b1);
    end
    if (state_r == sdtw_pkg::ST_PUSH && out_free) begin
      out_r <= pend_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  `SDTW_ASSERT(a_xlate_starts_walk,
    in_fire && in_op == sdtw_pkg::OP_XLATE |=> state_r == sdtw_pkg::ST_L1)
  `SDTW_ASSERT_ALWAYS(a_no_write_mid_walk,
    (state_r == sdtw_pkg::ST_L1 || state_r == sdtw_pkg::ST_L2 ||
     state_r == sdtw_pkg::ST_PUSH) |-> !ram_we)
  `SDTW_ASSERT(a_push_loads_output,
    state_r == sdtw_pkg::ST_PUSH && out_free |=> out_valid_r && state_r == sdtw_pkg::ST_IDLE)
  `SDTW_ASSERT(a_clear_blocks_input, state_r == sdtw_pkg::ST_CLEAR |-> !in_ready)

endmodule

@@ hw/rtl/short_descriptor_table_walk_unit.sv @@
// short-descriptor two-level table walker with private table memory
//
//  channel  dir  beat contents
//  in_*     in   tdata {data, address}, tuser opcode
//  out_*    out  tdata phys_addr, tuser fault
//  cfg_*    in   wr_data table_base, written when wr_en is high
//
// a write beat is taken in idle; a translation reads level 1 and, for a pointer, level 2,
// each read waiting on the registered ram output; in_tready is low until the walk is done
// after reset the ram is zeroed, one word a cycle, all 2^(WALK_ADDR_BITS-2) words
// (65536 at the default) with in_tready low; config writes are taken meanwhile
// a result waits in the output register; a finished walk holds until it drains
`timescale 1ns / 1ps

module short_descriptor_table_walk_unit #(
  parameter int WALK_ADDR_BITS = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] address, [63:32] data
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] phys_addr
  output logic        out_tuser,  // [0] fault
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int AW = WALK_ADDR_BITS - 2;

  logic [31:0]         table_base_r;
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [31:0]         ram_wdata;
  logic [31:0]         ram_rdata;
  sdtw_pkg::walk_res_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_base_r <= 32'h0;
    end else if (cfg_wr_en) begin
      table_base_r <= cfg_wr_data;
    end
  end

  sdtw_walk #(
    .WALK_ADDR_BITS(WALK_ADDR_BITS)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .table_base (table_base_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_addr    (in_tdata[31:0]),
    .in_data    (in_tdata[63:32]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata)
  );

  sdtw_ram #(
    .WIDTH(32),
    .DEPTH(1 << AW)
  ) u_table_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_tdata = out_res.phys_addr;
  assign out_tuser = out_res.fault;

endmodule

@@ bench/walk_checker.sv @@
// walk checker: mirrors the table ram, predicts every translation and compares results
`timescale 1ns / 1ps

module walk_checker #(
  parameter int WALK_ADDR_BITS = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] address, [63:32] data
  input  logic        in_tuser,   // [0] opcode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] phys_addr
  input  logic        out_tuser,  // [0] fault
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output int          mismatches,
  output int          walks_in_flight
);

  localparam int          WORDS        = 1 << (WALK_ADDR_BITS - 2);
  localparam logic [31:0] KEEP_SECTION = 32'hFFF0_0000;
  localparam logic [31:0] KEEP_SUPER   = 32'hFF00_0000;
  localparam logic [31:0] KEEP_SMALL   = 32'hFFFF_F000;
  localparam logic [31:0] KEEP_LARGE   = 32'hFFFF_0000;

  logic [31:0]         table_words [WORDS];
  logic [31:0]         l1_base;
  sdtw_pkg::walk_res_t walks_due [$];
  int                  result_no;

  // only the window bits of a byte address select a word
  function automatic logic [31:0] word_at(input logic [31:0] byte_addr);
    return table_words[byte_addr[WALK_ADDR_BITS-1:2]];
  endfunction

  function automatic sdtw_pkg::walk_res_t walk_predict(input logic [31:0] va);
    logic [31:0]         desc;
    logic [31:0]         keep;
    sdtw_pkg::walk_res_t res;
    desc = word_at({l1_base[31:14], va[31:20], 2'b00});
    if (desc[0]) begin
      desc = word_at({desc[31:10], 10'b0} + {22'b0, va[19:12], 2'b00});
      keep = desc[1] ? KEEP_SMALL : KEEP_LARGE;
    end else begin
      keep = desc[18] ? KEEP_SUPER : KEEP_SECTION;
    end
    if (desc[1:0] == 2'b00) begin
      res.phys_addr = 32'h0;
      res.fault     = 1'b1;
    end else begin
      res.phys_addr = (desc & keep) | (va & ~keep);
      res.fault     = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    sdtw_pkg::walk_res_t got;
    sdtw_pkg::walk_res_t want;
    if (!rst_n) begin
      foreach (table_words[i]) table_words[i] = 32'h0;
      l1_base = 32'h0;
      walks_due.delete();
      mismatches = 0;
      result_no  = 0;
    end else begin
      if (cfg_wr_en) l1_base = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        got.phys_addr = out_tdata;
        got.fault     = out_tuser;
        if (walks_due.size() == 0) begin
          if (mismatches < 10)
            $display("result beat %0d with no walk outstanding: pa %h fault %b",
                     result_no, got.phys_addr, got.fault);
          mismatches++;
        end else begin
          want = walks_due.pop_front();
          if (got.phys_addr !== want.phys_addr || got.fault !== want.fault) begin
            if (mismatches < 10)
              $display("result beat %0d: expected pa %h fault %b, got pa %h fault %b",
                       result_no, want.phys_addr, want.fault, got.phys_addr, got.fault);
            mismatches++;
          end
        end
        result_no++;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == sdtw_pkg::OP_WRITE) begin
          table_words[in_tdata[WALK_ADDR_BITS-1:2]] = in_tdata[63:32];
        end else begin
          walks_due.push_back(walk_predict(in_tdata[31:0]));
        end
      end
    end
    walks_in_flight = walks_due.size();
  end

endmodule

@@ bench/tb.sv @@
// testbench top: feeds table writes and translations to the walker under varied flow control
`timescale 1ns / 1ps

module tb;

  localparam int          WALK_ADDR_BITS = 18;
  localparam int          LIMIT_CYCLES   = 1_000_000;
  localparam int          PHASES         = 8;
  localparam int          PHASE_BEATS    = 215;
  localparam int          HOLD_CYCLES    = 300;
  localparam logic [31:0] WINDOW_MASK    = ((32'd1 << WALK_ADDR_BITS) - 1) & ~32'd3;

  typedef enum int {
    FLOW_FREE,
    FLOW_SENDER_IDLE,
    FLOW_SINK_STALL,
    FLOW_BOTH_LIGHT
  } flow_t;

  typedef enum int {
    SHAPE_SECTION,
    SHAPE_SUPER,
    SHAPE_SMALL,
    SHAPE_LARGE,
    SHAPE_L2_FAULT,
    SHAPE_L1_FAULT,
    SHAPE_NO_LEAF
  } shape_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata    = 64'h0;
  logic        in_tuser    = sdtw_pkg::OP_WRITE;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = 32'h0;

  int          mismatches;
  int          walks_in_flight;
  int          gap_pct     = 0;
  int          stall_pct   = 0;
  logic        hold_req    = 1'b0;
  logic        hold_seen   = 1'b0;
  int          hold_left   = 0;
  int          cycle_count = 0;
  int          beats_sent  = 0;
  logic [31:0] cur_base    = 32'h0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  short_descriptor_table_walk_unit #(
    .WALK_ADDR_BITS(WALK_ADDR_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  walk_checker #(
    .WALK_ADDR_BITS(WALK_ADDR_BITS)
  ) walk_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatches     (mismatches),
    .walks_in_flight(walks_in_flight)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when the stimulus asks for one
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // entered and left at a falling edge
  task automatic send_beat(input logic op, input logic [31:0] addr, input logic [31:0] dat);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {dat, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic put_word(input logic [31:0] addr, input logic [31:0] dat);
    send_beat(sdtw_pkg::OP_WRITE, addr, dat);
  endtask

  // data is ignored by a translation but still toggled
  task automatic xlate(input logic [31:0] va);
    send_beat(sdtw_pkg::OP_XLATE, va, $urandom);
  endtask

  function automatic logic [31:0] l1_slot(input logic [31:0] va);
    return {cur_base[31:14], va[31:20], 2'b00};
  endfunction

  // same word, random bits outside the window and in the byte offset
  function automatic logic [31:0] alias_addr(input logic [31:0] a);
    return (a & WINDOW_MASK) | ($urandom & ~WINDOW_MASK);
  endfunction

  task automatic set_base(input logic [31:0] v);
    in_tvalid <= 1'b0;
    while (walks_in_flight != 0) @(negedge clk);
    // table writes reach the ram when they are accepted, so none is left pending here
    repeat (8) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_base = v;
  endtask

  task automatic random_burst();
    logic [31:0] va;
    logic [31:0] desc;
    logic [31:0] leaf;
    logic [31:0] l2_slot;
    int          pick;
    shape_t      shape;
    pick = $urandom_range(99);
    va   = $urandom;
    if (pick < 15) begin
      put_word($urandom, $urandom);
    end else if (pick < 30) begin
      xlate(va);
    end else begin
      shape = shape_t'($urandom_range(6));
      desc  = $urandom;
      leaf  = $urandom;
      case (shape)
        SHAPE_SECTION: begin
          desc[1:0] = 2'b10;
          desc[18]  = 1'b0;
        end
        SHAPE_SUPER: begin
          desc[1:0] = 2'b10;
          desc[18]  = 1'b1;
        end
        SHAPE_L1_FAULT: desc[1:0] = 2'b00;
        default:        desc[0] = 1'b1;
      endcase
      case (shape)
        SHAPE_SMALL:    leaf[1] = 1'b1;
        SHAPE_LARGE:    leaf[1:0] = 2'b01;
        SHAPE_L2_FAULT: leaf[1:0] = 2'b00;
        default: ;
      endcase
      put_word(alias_addr(l1_slot(va)), desc);
      // a pointer with no leaf written walks into whatever is left there
      if (desc[0] && shape != SHAPE_NO_LEAF) begin
        l2_slot = {desc[31:10], 10'b0} + {22'b0, va[19:12], 2'b00};
        put_word(alias_addr(l2_slot), leaf);
      end
      xlate(va);
      if ($urandom_range(2) == 0) xlate(va ^ ($urandom & 32'h0000_0FFF));
    end
  endtask

  initial begin
    flow_t flow;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // low bits of the base are ignored
    set_base(32'h1234_5678);
    xlate(32'h0000_0000);
    xlate(32'hFFFF_FFFF);
    // section, then its last byte
    put_word(l1_slot(32'h0010_0ABC), 32'hABC0_0C02);
    xlate(32'h0010_0ABC);
    xlate(32'h001F_FFFF);
    // supersection written through an aliased, unaligned address
    put_word(l1_slot(32'hFF34_5678) | 32'hFFFC_0003, 32'h5A04_0002);
    xlate(32'hFF34_5678);
    // pointer with both low bits set, small page below it
    put_word(l1_slot(32'h7FF0_1234), 32'h0003_0003);
    put_word(32'h0003_0004, 32'hCAFE_B002);
    xlate(32'h7FF0_1234);
    // pointer at the top of the address space, large page in its last slot
    put_word(l1_slot(32'h800F_F678), 32'hFFFF_FC01);
    put_word(32'hFFFF_FFFC, 32'hFFFF_FFFD);
    xlate(32'h800F_F678);
    // same level-1 entry, first slot invalid
    put_word(32'hFFFF_FC00, 32'hFFFF_FFFC);
    xlate(32'h8000_0000);
    // invalid level-1 entry with every other bit set
    put_word(l1_slot(32'h4000_0000), 32'hFFFF_FFFC);
    xlate(32'h4000_0000);
    put_word(l1_slot(32'h0010_0ABC), 32'h0000_0000);
    xlate(32'h0010_0ABC);

    for (int ph = 0; ph < PHASES; ph++) begin
      flow = flow_t'(ph % 4);
      case (flow)
        FLOW_FREE: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        FLOW_SENDER_IDLE: begin
          gap_pct   = 85;
          stall_pct = 0;
        end
        FLOW_SINK_STALL: begin
          gap_pct   = 0;
          stall_pct = 85;
        end
        default: begin
          gap_pct   = 8;
          stall_pct = 8;
        end
      endcase
      if (ph == 0) set_base(32'h0000_0000);
      else if (ph == 1) set_base(32'hFFFF_FFFF);
      else set_base($urandom);
      // long sink hold-off while beats keep coming, so the walker backs up
      if (flow == FLOW_FREE) hold_req <= ~hold_req;
      beats_sent = 0;
      while (beats_sent < PHASE_BEATS) random_burst();
    end

    in_tvalid <= 1'b0;
    while (walks_in_flight != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatches == 0 && walks_in_flight == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
